// ===== hw/rtl/awcl_pkg.sv =====
// Shared types and constants for the alpha-weighted colour blend.
`default_nettype none
package awcl_pkg;
	localparam int unsigned CompBits = 16;
	localparam int unsigned Lanes = 3;

	typedef enum logic [1:0] {
		MODE_EQUAL = 2'd0,
		MODE_FIRST = 2'd1,
		MODE_SECOND = 2'd2,
		MODE_WEIGHT = 2'd3
	} mode_t;
endpackage
`default_nettype wire

// ===== hw/rtl/awcl_div.sv =====
// Pipelined restoring divider with saturation: one quotient bit per stage.
`default_nettype none
module awcl_div #(
	parameter int unsigned NUM_W = 50,
	parameter int unsigned DEN_W = 34,
	parameter int unsigned Q_W = 16
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [NUM_W-1:0] num,
	input wire logic [DEN_W-1:0] den,
	output logic [Q_W-1:0] quo
);
	// Quotient saturates: if num >= den << Q_W, the result is all ones.
	localparam int unsigned R_W = DEN_W + 1;
	localparam int unsigned LO_W = Q_W;

	logic [R_W-1:0] rem_q [Q_W+1];
	logic [DEN_W-1:0] den_q [Q_W+1];
	logic [LO_W-1:0] low_q [Q_W+1];
	logic [Q_W-1:0] quo_q [Q_W+1];
	logic sat_q [Q_W+1];

	logic [NUM_W-1:0] hi_part;
	logic [NUM_W:0] den_sh;

	always_comb begin
		hi_part = num >> Q_W;
		den_sh = {{(NUM_W+1-DEN_W){1'b0}}, den};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_q[0] <= ({1'b0, hi_part} >= den_sh);
			rem_q[0] <= R_W'(hi_part);
			den_q[0] <= den;
			low_q[0] <= num[LO_W-1:0];
			quo_q[0] <= '0;
		end
	end

	for (genvar s = 0; s < Q_W; s++) begin : g_st
		logic [R_W:0] sh;
		logic ge;
		always_comb begin
			sh = {rem_q[s], low_q[s][LO_W-1]};
			ge = sh >= {2'b0, den_q[s]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s+1] <= ge ? R_W'(sh - {2'b0, den_q[s]}) : R_W'(sh);
				den_q[s+1] <= den_q[s];
				low_q[s+1] <= low_q[s] << 1;
				quo_q[s+1] <= {quo_q[s][Q_W-2:0], ge};
				sat_q[s+1] <= sat_q[s];
			end
		end
	end

	assign quo = sat_q[Q_W] ? '1 : quo_q[Q_W];
endmodule
`default_nettype wire

// ===== hw/rtl/awcl_lane.sv =====
// One colour channel lane: plain blend and weighted quotient.
`default_nettype none
module awcl_lane #(
	parameter int unsigned CB = awcl_pkg::CompBits
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [CB-1:0] c1,
	input wire logic [CB-1:0] c2,
	input wire logic [CB:0] x_s1,
	input wire logic [CB:0] nx_s1,
	input wire logic [2*CB+1:0] w1_s2,
	input wire logic [2*CB+1:0] w2_s2,
	input wire logic [2*CB+1:0] blend_s3,
	output logic [CB-1:0] plain_o,
	output logic [CB-1:0] quo_o
);
	localparam int unsigned WW = 2*CB + 2;
	localparam int unsigned NW = 3*CB + 3;

	logic [CB-1:0] c1_s1, c2_s1, c1_s2, c2_s2;
	logic [2*CB+1:0] p2_s2, p1_s2;
	logic [CB-1:0] plain_s3;
	logic [NW-1:0] m2_s3, m1_s3;
	logic [2*CB+1:0] psum;
	logic [CB-1:0] pl_pipe [CB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s1 <= c1;
			c2_s1 <= c2;
			p2_s2 <= WW'(x_s1 * c2_s1);
			p1_s2 <= WW'(nx_s1 * c1_s1);
			c1_s2 <= c1_s1;
			c2_s2 <= c2_s1;
			plain_s3 <= (psum[2*CB+1:CB] > (CB+2)'({CB{1'b1}})) ? '1 : psum[2*CB-1:CB];
			m2_s3 <= NW'(w2_s2 * c2_s2);
			m1_s3 <= NW'(w1_s2 * c1_s2);
		end
	end

	assign psum = p2_s2 + p1_s2;

	awcl_div #(.NUM_W(NW), .DEN_W(WW), .Q_W(CB)) u_div (
		.clk, .en,
		.num(m2_s3 + m1_s3),
		.den(blend_s3),
		.quo(quo_o)
	);

	// plain result delayed to meet the divider output
	always_ff @(posedge clk) begin
		if (en) pl_pipe[0] <= plain_s3;
	end
	for (genvar i = 0; i < CB; i++) begin : g_pl
		always_ff @(posedge clk) begin
			if (en) pl_pipe[i+1] <= pl_pipe[i];
		end
	end
	assign plain_o = pl_pipe[CB];
endmodule
`default_nettype wire

// ===== hw/rtl/alpha_weighted_colour_lerp.sv =====
// Top level: three colour lanes, alpha path and output merge.
//
// Channels: input item (two RGBA colours and a position) with in_valid /
// in_stall; result item (RGBA) with out_valid / out_stall. Both are valid/stall:
// a transfer happens on a clock edge with valid high and stall low.
// Throughput: one item per clock unless stalled. The pipeline advances whenever
// its output register is empty or being taken, so a new item enters while a
// result waits only if the output slot frees; in_stall is out_stall while that
// slot is full. A result passes through COMPONENT_BITS + 5 register stages set
// by the bit-per-stage divider that forms the alpha-weighted RGB quotient
// (input, product and blend stages, a divider setup stage, one stage per
// quotient bit, then the merge register).
// Reset clears all valid bits; payload registers are not reset.
// When out_stall meets a waiting result, the whole pipeline holds in place.
// Position values above one are treated as exactly one.
`default_nettype none
module alpha_weighted_colour_lerp #(
	parameter int unsigned COMPONENT_BITS = awcl_pkg::CompBits
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [COMPONENT_BITS-1:0] first_red,
	input wire logic [COMPONENT_BITS-1:0] first_green,
	input wire logic [COMPONENT_BITS-1:0] first_blue,
	input wire logic [COMPONENT_BITS-1:0] first_alpha,
	input wire logic [COMPONENT_BITS-1:0] second_red,
	input wire logic [COMPONENT_BITS-1:0] second_green,
	input wire logic [COMPONENT_BITS-1:0] second_blue,
	input wire logic [COMPONENT_BITS-1:0] second_alpha,
	input wire logic [COMPONENT_BITS:0] position,
	output logic out_valid,
	input wire logic out_stall,
	output logic [COMPONENT_BITS-1:0] out_red,
	output logic [COMPONENT_BITS-1:0] out_green,
	output logic [COMPONENT_BITS-1:0] out_blue,
	output logic [COMPONENT_BITS-1:0] out_alpha
);
	import awcl_pkg::*;
	localparam int unsigned CB = COMPONENT_BITS;
	localparam int unsigned LAT = CB + 4;
	localparam logic [CB:0] PosOne = (CB+1)'(1) << CB;

	logic en;
	logic [LAT-1:0] vld_q;
	logic [CB-1:0] c1 [Lanes], c2 [Lanes], plain [Lanes], quo [Lanes];
	logic [CB:0] xs, x_s1, nx_s1;
	logic [CB-1:0] a1_s1, a2_s1;
	logic [CB-1:0] a1_s1_d;
	mode_t mode_s1, mode_s2, mode_s3;
	logic [2*CB+1:0] w1_s2, w2_s2, blend_s3;
	logic [CB-1:0] alpha_s3;
	mode_t mode_p [CB+1];
	logic [CB-1:0] alpha_p [CB+1];
	logic [CB-1:0] c1_p [CB+4][Lanes];
	logic [CB-1:0] c2_p [CB+4][Lanes];
	logic [CB-1:0] red_q, green_q, blue_q, alpha_q;
	logic valid_q;

	assign en = !valid_q || !out_stall;
	assign in_stall = !en;

	assign c1[0] = first_red;
	assign c1[1] = first_green;
	assign c1[2] = first_blue;
	assign c2[0] = second_red;
	assign c2[1] = second_green;
	assign c2[2] = second_blue;
	assign xs = (position > PosOne) ? PosOne : position;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
			valid_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xs;
			nx_s1 <= PosOne - xs;
			a1_s1 <= first_alpha;
			a2_s1 <= second_alpha;
			if (first_alpha == second_alpha) mode_s1 <= MODE_EQUAL;
			else if (second_alpha == '0) mode_s1 <= MODE_FIRST;
			else if (first_alpha == '0) mode_s1 <= MODE_SECOND;
			else mode_s1 <= MODE_WEIGHT;
			w1_s2 <= (2*CB+2)'(nx_s1 * a1_s1);
			w2_s2 <= (2*CB+2)'(x_s1 * a2_s1);
			mode_s2 <= mode_s1;
			mode_s3 <= mode_s2;
			blend_s3 <= w1_s2 + w2_s2;
			case (mode_s2)
				MODE_EQUAL: alpha_s3 <= a1_s1_d;
				MODE_FIRST: alpha_s3 <= sat_fn(w1_s2);
				MODE_SECOND: alpha_s3 <= sat_fn(w2_s2);
				default: alpha_s3 <= sat_fn(w1_s2 + w2_s2);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) a1_s1_d <= a1_s1;
	end

	function automatic logic [CB-1:0] sat_fn(input logic [2*CB+1:0] v);
		logic [CB+1:0] h;
		h = v[2*CB+1:CB];
		return (h > (CB+2)'({CB{1'b1}})) ? '1 : h[CB-1:0];
	endfunction

	for (genvar l = 0; l < Lanes; l++) begin : g_lane
		awcl_lane #(.CB(CB)) u_lane (
			.clk, .en,
			.c1(c1[l]), .c2(c2[l]),
			.x_s1, .nx_s1, .w1_s2, .w2_s2, .blend_s3,
			.plain_o(plain[l]), .quo_o(quo[l])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				c1_p[0][l] <= c1[l];
				c2_p[0][l] <= c2[l];
			end
		end
		for (genvar i = 0; i < CB + 3; i++) begin : g_cp
			always_ff @(posedge clk) begin
				if (en) begin
					c1_p[i+1][l] <= c1_p[i][l];
					c2_p[i+1][l] <= c2_p[i][l];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_p[0] <= mode_s3;
			alpha_p[0] <= alpha_s3;
		end
	end
	for (genvar i = 0; i < CB; i++) begin : g_mp
		always_ff @(posedge clk) begin
			if (en) begin
				mode_p[i+1] <= mode_p[i];
				alpha_p[i+1] <= alpha_p[i];
			end
		end
	end

	// merge: pick the lane result the case calls for
	logic [CB-1:0] sel [Lanes];
	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			case (mode_p[CB])
				MODE_EQUAL: sel[l] = plain[l];
				MODE_FIRST: sel[l] = c1_p[CB+3][l];
				MODE_SECOND: sel[l] = c2_p[CB+3][l];
				default: sel[l] = quo[l];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_q <= sel[0];
			green_q <= sel[1];
			blue_q <= sel[2];
			alpha_q <= alpha_p[CB];
		end
	end

	assign out_valid = valid_q;
	assign out_red = red_q;
	assign out_green = green_q;
	assign out_blue = blue_q;
	assign out_alpha = alpha_q;

`ifndef SYNTH
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_q && out_stall))
		else $error("input stalled while output slot free");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |=> (valid_q && $stable(vld_q)))
		else $error("pipeline moved during output stall");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[LAT-1]) |=> valid_q)
		else $error("result lost at merge");
`endif
endmodule
`default_nettype wire

// ===== tb/lerp_checker.sv =====
// Checker: watches both channels, predicts each blended colour and compares.
`default_nettype none
module lerp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [15:0] first_red,
	input wire logic [15:0] first_green,
	input wire logic [15:0] first_blue,
	input wire logic [15:0] first_alpha,
	input wire logic [15:0] second_red,
	input wire logic [15:0] second_green,
	input wire logic [15:0] second_blue,
	input wire logic [15:0] second_alpha,
	input wire logic [16:0] position,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [15:0] out_red,
	input wire logic [15:0] out_green,
	input wire logic [15:0] out_blue,
	input wire logic [15:0] out_alpha,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] r, g, b, a;
	} rgba_t;

	rgba_t expected_colours[$];

	function automatic logic [15:0] clamp16(logic [127:0] v);
		return (v > 128'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic rgba_t blend_colour(logic [15:0] c1[3], logic [15:0] a1,
			logic [15:0] c2[3], logic [15:0] a2, logic [16:0] pos);
		rgba_t res;
		logic [16:0] x, nx;
		logic [63:0] w1, w2, mix;
		logic [127:0] num;
		logic [15:0] lane[3];
		x = (pos > 17'h10000) ? 17'h10000 : pos;
		nx = 17'h10000 - x;
		w1 = nx * a1;
		w2 = x * a2;
		mix = w1 + w2;
		for (int k = 0; k < 3; k++) begin
			if (a1 == a2)
				lane[k] = clamp16((64'(x) * c2[k] + 64'(nx) * c1[k]) >> 16);
			else if (a2 == 0)
				lane[k] = c1[k];
			else if (a1 == 0)
				lane[k] = c2[k];
			else if (mix == 0)
				lane[k] = 0;
			else begin
				num = 128'(w2) * c2[k] + 128'(w1) * c1[k];
				lane[k] = clamp16(num / mix);
			end
		end
		res.r = lane[0];
		res.g = lane[1];
		res.b = lane[2];
		if (a1 == a2)
			res.a = a1;
		else if (a2 == 0)
			res.a = clamp16(w1 >> 16);
		else if (a1 == 0)
			res.a = clamp16(w2 >> 16);
		else
			res.a = (mix == 0) ? 16'd0 : clamp16(mix >> 16);
		return res;
	endfunction

	initial fail_count = 0;

	always @(posedge clk) begin
		rgba_t want;
		rgba_t got;
		if (arst_n && in_valid && !in_stall)
			expected_colours.push_back(blend_colour(
				'{first_red, first_green, first_blue}, first_alpha,
				'{second_red, second_green, second_blue}, second_alpha, position));
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_red, out_green, out_blue, out_alpha};
			if (expected_colours.size() == 0) begin
				$display("%0t: unexpected transfer rgba=%h", $time, got);
				fail_count++;
			end else begin
				want = expected_colours.pop_front();
				if (got.r != want.r) begin
					$display("%0t: red exp %h got %h", $time, want.r, got.r);
					fail_count++;
				end
				if (got.g != want.g) begin
					$display("%0t: green exp %h got %h", $time, want.g, got.g);
					fail_count++;
				end
				if (got.b != want.b) begin
					$display("%0t: blue exp %h got %h", $time, want.b, got.b);
					fail_count++;
				end
				if (got.a != want.a) begin
					$display("%0t: alpha exp %h got %h", $time, want.a, got.a);
					fail_count++;
				end
			end
		end
		pending = expected_colours.size();
	end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top: clock, reset, stimulus, receiver stalls and verdict.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 1250;
	localparam int IdleLimit = 4000;
	localparam int Latency = 21;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [15:0] first_red = 0, first_green = 0, first_blue = 0, first_alpha = 0;
	logic [15:0] second_red = 0, second_green = 0, second_blue = 0, second_alpha = 0;
	logic [16:0] position = 0;
	logic out_valid;
	logic out_stall = 1;
	logic [15:0] out_red, out_green, out_blue, out_alpha;
	int fail_count, pending;
	int idle_cycles = 0;
	bit long_hold = 0;

	always #4 clk = ~clk;

	alpha_weighted_colour_lerp dut (.*);
	lerp_checker checker_i (.*);

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold requested by the stimulus
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1;
				repeat (200) @(negedge clk);
				long_hold = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				out_stall <= 1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 0;
		end
	end

	task automatic send_colour(logic [15:0] r1, g1, b1, a1, r2, g2, b2, a2,
			logic [16:0] pos, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		{first_red, first_green, first_blue, first_alpha} <= {r1, g1, b1, a1};
		{second_red, second_green, second_blue, second_alpha} <= {r2, g2, b2, a2};
		position <= pos;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_comp();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [16:0] pick_pos();
		case ($urandom_range(0, 7))
			0: return 17'h00000;
			1: return 17'h10000;
			2: return 17'h1FFFF - 17'($urandom_range(0, 'hFFFE));
			3: return 17'h0FFFF;
			default: return 17'($urandom_range(0, 'h10000));
		endcase
	endfunction

	initial begin
		logic [15:0] a1, a2;
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// equal alphas, both zero, one zero, weighted, extreme positions
		send_colour('1, '1, '1, '1, '0, '0, '0, '1, 17'h00000, 0);
		send_colour('1, '1, '1, '1, '0, '0, '0, '1, 17'h10000, 0);
		send_colour('1, 0, '1, 0, 0, '1, 0, 0, 17'h08000, 0);
		send_colour('1, '1, '1, '1, 1, 2, 3, 0, 17'h04000, 0);
		send_colour(5, 6, 7, 0, '1, '1, '1, '1, 17'h0C000, 0);
		send_colour('1, 0, '1, 1, 0, '1, 0, '1, 17'h0FFFF, 0);
		send_colour('1, '1, '1, '1, 0, 0, 0, 1, 17'h00001, 0);
		send_colour(0, 0, 0, 1, '1, '1, '1, '1, 17'h1FFFF, 0);
		send_colour('1, '1, '1, 16'h8000, '1, '1, '1, 16'h7FFF, 17'h10001, 0);
		send_colour(16'h1234, 16'hABCD, 16'h5555, '1, 16'hAAAA, 0, '1, 16'h00FF,
			17'h10000, 0);
		send_colour(16'h1234, 16'hABCD, 16'h5555, '1, 16'hAAAA, 0, '1, 16'h00FF,
			17'h00000, 0);
		// long receiver hold while the sender keeps offering
		long_hold = 1;
		for (int i = 0; i < 60; i++)
			send_colour(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				17'($urandom_range(0, 'h1FFFF)), 1);
		for (int i = 0; i < RandomItems; i++) begin
			a1 = pick_comp();
			case ($urandom_range(0, 9))
				0, 1: a2 = a1;
				2: a2 = 0;
				3: begin a1 = 0; a2 = pick_comp(); end
				default: a2 = pick_comp();
			endcase
			send_colour(pick_comp(), pick_comp(), pick_comp(), a1, pick_comp(),
				pick_comp(), pick_comp(), a2, pick_pos(), $urandom_range(0, 3) == 0);
			if (i == RandomItems / 2) begin
				// drain everything before going on
				in_valid <= 0;
				while (pending != 0) @(negedge clk);
			end
		end
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (Latency + 5) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
